### sv/bwc_pkg.sv
// Shared types and constants for the barcode whitelist corrector.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package bwc_pkg;

  // Fixed port widths
  localparam int BARCODE_W = 48;
  localparam int BASE_W    = 3;
  localparam int LEN_W     = 5;
  localparam int STATUS_W  = 3;

  // Default sizes handed to the top level
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_BASES   = 16;

  // Length register value after reset
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  // Base codes: A=0 G=1 C=2 T=3, N=4, 5..7 odd bases
  localparam logic [BASE_W-1:0] BASE_N = 3'd4;

  // Mismatch counter codes carried along the cell row
  localparam logic [1:0] MISS_NONE = 2'd0;
  localparam logic [1:0] MISS_ONE  = 2'd1;
  localparam logic [1:0] MISS_MANY = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXACT     = 3'd0,
    ST_CORRECTED = 3'd1,
    ST_NOMATCH   = 3'd2,
    ST_AMBIGUOUS = 3'd3,
    ST_STORED    = 3'd4,
    ST_DUPLICATE = 3'd5,
    ST_IGNORED   = 3'd6
  } status_t;

  // Compare token passed from cell to cell with one table entry
  typedef struct packed {
    logic                 valid;
    logic [1:0]           miss;  // mismatches so far, saturating at MISS_MANY
    logic [LEN_W-1:0]     pos;   // position of the first mismatch
    logic [BASE_W-1:0]    base;  // entry base at that position
  } tok_t;

endpackage

### sv/bwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bwc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bwc_cell.sv
// One base-position cell of the compare row: holds one query base and
// updates the mismatch token of the entry passing through. Uses bwc_pkg.
module bwc_cell #(
  parameter int MAX_BASES = 16,
  parameter int IDX       = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [bwc_pkg::BASE_W-1:0]        load_base,
  input  logic                              load_en,
  input  bwc_pkg::tok_t                     tok_in,
  input  logic [bwc_pkg::BASE_W*MAX_BASES-1:0] ent_in,
  output bwc_pkg::tok_t                     tok_out,
  output logic [bwc_pkg::BASE_W*MAX_BASES-1:0] ent_out
);

  logic [bwc_pkg::BASE_W-1:0]            q_base_r;
  logic                                  en_r;
  logic                                  tok_valid_r;
  logic [1:0]                            miss_r;
  logic [bwc_pkg::LEN_W-1:0]             pos_r;
  logic [bwc_pkg::BASE_W-1:0]            base_r;
  logic [bwc_pkg::BASE_W*MAX_BASES-1:0]  ent_r;

  logic [bwc_pkg::BASE_W-1:0]            e_base;
  logic                                  diff;
  logic [1:0]                            miss_nxt;
  logic [bwc_pkg::LEN_W-1:0]             pos_nxt;
  logic [bwc_pkg::BASE_W-1:0]            base_nxt;

  assign e_base = ent_in[IDX*bwc_pkg::BASE_W +: bwc_pkg::BASE_W];
  assign diff   = en_r && (e_base != q_base_r);

  // Mismatch count update; first mismatch records where and what
  always_comb begin
    miss_nxt = tok_in.miss;
    pos_nxt  = tok_in.pos;
    base_nxt = tok_in.base;
    if (diff) begin
      if (tok_in.miss == bwc_pkg::MISS_NONE) begin
        miss_nxt = bwc_pkg::MISS_ONE;
        pos_nxt  = bwc_pkg::LEN_W'(IDX);
        base_nxt = e_base;
      end else begin
        miss_nxt = bwc_pkg::MISS_MANY;
      end
    end
  end

  // Query base load and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
    if (load) begin
      q_base_r <= load_base;
      en_r     <= load_en;
    end
    miss_r <= miss_nxt;
    pos_r  <= pos_nxt;
    base_r <= base_nxt;
    ent_r  <= ent_in;
  end

  assign tok_out = '{valid: tok_valid_r, miss: miss_r, pos: pos_r, base: base_r};
  assign ent_out = ent_r;

endmodule

### sv/barcode_whitelist_corrector.sv
// Top level of the barcode whitelist corrector: control, table RAM and
// the row of compare cells. Uses bwc_pkg, bwc_ram and bwc_cell.
//
// Usage
//   Input: drive in_func / in_barcode and raise start; the beat is taken
//   at a clock edge where start is high and busy is low. in_func 0 loads
//   a whitelist entry, 1 queries a barcode.
//   Output: each beat yields one result, shown on out_status and
//   out_result_barcode for exactly one cycle with out_valid high. The
//   receiver cannot stall; results must be taken when shown.
//   Config: cfg_wr_en / cfg_wr_data write the length register (bases in
//   use); write only while busy is low and no result is pending.
//   Scan: with N stored entries the table is read one entry per cycle
//   and every entry then walks the row of MAX_BASES cells before the
//   result is decided. An ignored load or an empty table skips the scan
//   and drain and goes straight to the finishing state. One item at a
//   time; a new beat can be taken in the cycle the result strobe is high.
//   Reset (synchronous, rst_n low): entry count and the collision stop
//   flag clear, the length returns to 16. The table RAM is not cleared;
//   only entries below the count are ever read.
module barcode_whitelist_corrector #(
  parameter int TABLE_DEPTH = bwc_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_BASES   = bwc_pkg::DEF_MAX_BASES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [bwc_pkg::BARCODE_W-1:0]  in_barcode,
  output logic                           out_valid,
  output logic [bwc_pkg::STATUS_W-1:0]   out_status,
  output logic [bwc_pkg::BARCODE_W-1:0]  out_result_barcode,
  input  logic                           cfg_wr_en,
  input  logic [bwc_pkg::LEN_W-1:0]      cfg_wr_data
);

  localparam int BW    = bwc_pkg::BASE_W * MAX_BASES;
  localparam int AW    = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int PW    = MAX_BASES > 1 ? $clog2(MAX_BASES) : 1;
  localparam int HW    = 4 * MAX_BASES;
  localparam int DW    = $clog2(MAX_BASES + 1);
  localparam int LW    = bwc_pkg::LEN_W;
  localparam int SW    = bwc_pkg::BASE_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t                    state_r;
  logic [CW-1:0]             cnt_r;
  logic                      stop_r;
  logic [LW-1:0]             len_cfg_r;
  logic [CW-1:0]             idx_r;
  logic [DW-1:0]             drn_r;
  logic                      rd_v_r;
  logic                      func_r;
  logic                      ign_r;
  logic [BW-1:0]             q_r;
  logic                      nzero_r;
  logic                      none_r;
  logic [LW-1:0]             npos_r;
  logic                      exact_r;
  logic [MAX_BASES-1:0][3:0] hit_r;
  logic [LW-1:0]             fpos_r;
  logic [SW-1:0]             fbase_r;
  logic                      out_valid_r;
  bwc_pkg::status_t          out_status_r;
  logic [bwc_pkg::BARCODE_W-1:0] out_bc_r;

  logic                      accept;
  logic [LW-1:0]             len_eff;
  logic [MAX_BASES-1:0]      base_en;
  logic [BW-1:0]             len_mask;
  logic [BW-1:0]             q_in;
  logic [MAX_BASES-1:0]      nmask;
  logic [LW-1:0]             npos_now;
  logic                      ign_now;
  logic [BW-1:0]             rdata;
  logic                      ram_we;
  bwc_pkg::tok_t             tok   [MAX_BASES+1];
  logic [BW-1:0]             ent   [MAX_BASES+1];
  bwc_pkg::tok_t             tok_end;
  logic                      cand_ok;
  logic [HW-1:0]             hit_flat;
  logic                      hit_one;
  logic [BW-1:0]             q_masked;
  logic [BW-1:0]             corr;
  bwc_pkg::status_t          fin_status;
  logic [BW-1:0]             fin_bc;
  logic                      fin_store;
  logic                      fin_dup;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign q_in   = BW'(in_barcode);

  // Effective length: zero acts as one, clipped to MAX_BASES
  always_comb begin
    len_eff = len_cfg_r;
    if (len_cfg_r == '0) begin
      len_eff = LW'(1);
    end else if (len_cfg_r > LW'(MAX_BASES)) begin
      len_eff = LW'(MAX_BASES);
    end
  end

  // Per-base enables, bit mask and N positions of the incoming barcode
  always_comb begin
    npos_now = '0;
    for (int k = 0; k < MAX_BASES; k++) begin
      base_en[k]            = (LW'(k) < len_eff);
      len_mask[k*SW +: SW]  = {SW{base_en[k]}};
      nmask[k]              = base_en[k] && (q_in[k*SW +: SW] == bwc_pkg::BASE_N);
      if (nmask[k]) begin
        npos_now = npos_now | LW'(k);
      end
    end
  end

  assign ign_now = !in_func && (stop_r || (cnt_r == CW'(TABLE_DEPTH)));

  // Table storage
  assign ram_we = (state_r == S_FINISH) && fin_store;

  bwc_ram #(
    .WIDTH (BW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (q_r),
    .re    (state_r == S_SCAN),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // Row of compare cells, one per base position
  assign tok[0] = '{valid: rd_v_r, miss: bwc_pkg::MISS_NONE, pos: '0, base: '0};
  assign ent[0] = rdata;

  for (genvar g = 0; g < MAX_BASES; g++) begin : g_cell
    bwc_cell #(
      .MAX_BASES (MAX_BASES),
      .IDX       (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (accept),
      .load_base (q_in[g*SW +: SW]),
      .load_en   (base_en[g]),
      .tok_in    (tok[g]),
      .ent_in    (ent[g]),
      .tok_out   (tok[g+1]),
      .ent_out   (ent[g+1])
    );
  end

  assign tok_end = tok[MAX_BASES];

  // An entry one base away is a candidate if that base is A/G/C/T, the query
  // has at most one N and, if it has one, the difference sits at the N
  assign cand_ok = (tok_end.miss == bwc_pkg::MISS_ONE) && (tok_end.base < bwc_pkg::BASE_N)
                   && (nzero_r || (none_r && (tok_end.pos == npos_r)));

  assign hit_flat = hit_r;
  assign hit_one  = (hit_flat != '0) && ((hit_flat & (hit_flat - HW'(1))) == '0);
  assign q_masked = q_r & len_mask;

  // Corrected barcode: query with the recorded base substituted
  always_comb begin
    for (int k = 0; k < MAX_BASES; k++) begin
      corr[k*SW +: SW] = (LW'(k) == fpos_r) ? fbase_r : q_masked[k*SW +: SW];
    end
  end

  // Final decision
  always_comb begin
    fin_status = bwc_pkg::ST_NOMATCH;
    fin_bc     = '0;
    fin_store  = 1'b0;
    fin_dup    = 1'b0;
    if (!func_r) begin
      if (ign_r) begin
        fin_status = bwc_pkg::ST_IGNORED;
      end else if (exact_r) begin
        fin_status = bwc_pkg::ST_DUPLICATE;
        fin_dup    = 1'b1;
      end else begin
        fin_status = bwc_pkg::ST_STORED;
        fin_store  = 1'b1;
      end
    end else if (exact_r) begin
      fin_status = bwc_pkg::ST_EXACT;
      fin_bc     = q_masked;
    end else if (hit_flat == '0) begin
      fin_status = bwc_pkg::ST_NOMATCH;
    end else if (hit_one) begin
      fin_status = bwc_pkg::ST_CORRECTED;
      fin_bc     = corr;
    end else begin
      fin_status = bwc_pkg::ST_AMBIGUOUS;
    end
  end

  // Sequencer, status registers and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      stop_r      <= 1'b0;
      len_cfg_r   <= bwc_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_v_r      <= (state_r == S_SCAN);
      if (cfg_wr_en) begin
        len_cfg_r <= cfg_wr_data;
      end

      // Collect results at the end of the cell row
      if (tok_end.valid) begin
        if (tok_end.miss == bwc_pkg::MISS_NONE) begin
          exact_r <= 1'b1;
        end else if (cand_ok) begin
          hit_r[tok_end.pos[PW-1:0]][tok_end.base[1:0]] <= 1'b1;
          fpos_r  <= tok_end.pos;
          fbase_r <= tok_end.base;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r  <= in_func;
            q_r     <= q_in;
            ign_r   <= ign_now;
            nzero_r <= (nmask == '0);
            none_r  <= (nmask != '0) && ((nmask & (nmask - MAX_BASES'(1))) == '0);
            npos_r  <= npos_now;
            exact_r <= 1'b0;
            hit_r   <= '0;
            idx_r   <= '0;
            if (ign_now || (cnt_r == '0)) begin
              state_r <= S_FINISH;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + CW'(1);
          if ((idx_r + CW'(1)) == cnt_r) begin
            drn_r   <= DW'(MAX_BASES);
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drn_r == '0) begin
            state_r <= S_FINISH;
          end else begin
            drn_r <= drn_r - DW'(1);
          end
        end
        S_FINISH: begin
          out_valid_r  <= 1'b1;
          out_status_r <= fin_status;
          out_bc_r     <= bwc_pkg::BARCODE_W'(fin_bc);
          if (fin_store) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (fin_dup) begin
            stop_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_barcode = out_bc_r;

endmodule

### sv/bwc_checker.sv
// Port-level checks for barcode_whitelist_corrector, bound to the top.
// Uses bwc_pkg status codes.
module bwc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [bwc_pkg::STATUS_W-1:0]   out_status,
  input logic [bwc_pkg::BARCODE_W-1:0]  out_result_barcode
);

  // An accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted beat");

  // A result strobe lasts one cycle and comes only when the block is idle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy ##1 !out_valid))
    else $error("result strobe not single or while busy");

  // Leaving busy always delivers the result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("busy ended without a result");

  // Only exact and corrected results carry a barcode
  a_zero_barcode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != bwc_pkg::ST_EXACT) && (out_status != bwc_pkg::ST_CORRECTED))
      |-> (out_result_barcode == '0))
    else $error("barcode nonzero for non-match status");

  // Status codes above ignored never appear
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= bwc_pkg::ST_IGNORED))
    else $error("status code out of range");

endmodule

bind barcode_whitelist_corrector bwc_checker u_bwc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_result_barcode (out_result_barcode)
);

### tb/barcode_whitelist_corrector_tb.sv
// Testbench for barcode_whitelist_corrector: a directed table of loads and queries,
// then random traffic over several length settings and a collision phase, checked by a predictor.
// Depends on bwc_pkg and the RTL top barcode_whitelist_corrector.
module barcode_whitelist_corrector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bwc_pkg::*;

  localparam int DEPTH          = DEF_TABLE_DEPTH;
  localparam int BASES          = DEF_MAX_BASES;
  localparam int ENTRY_CAP      = 140;
  // Longest quiet stretch of a correct run is one query over a full table
  // plus a sender gap; taken a few times over.
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [BASE_W-1:0] BASE_A   = 3'd0;
  localparam logic [BASE_W-1:0] BASE_G   = 3'd1;
  localparam logic [BASE_W-1:0] BASE_C   = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T   = 3'd3;
  localparam logic [BASE_W-1:0] BASE_ODD = 3'd5;

  localparam logic [BARCODE_W-1:0] ALL_ONES = {BARCODE_W{1'b1}};

  typedef enum logic {ROW_BEAT, ROW_LEN} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 func;
    logic [BARCODE_W-1:0] word;
    bit                   typed;
    status_t              st;
    logic [BARCODE_W-1:0] res;
  } row_t;

  typedef struct packed {
    status_t              st;
    logic [BARCODE_W-1:0] res;
  } answer_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  logic                 in_func     = 1'b0;
  logic [BARCODE_W-1:0] in_barcode  = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [BARCODE_W-1:0] out_result_barcode;
  logic                 cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0]     cfg_wr_data = '0;

  // Predictor state
  logic [BARCODE_W-1:0] whitelist[$];
  bit                   loads_frozen = 1'b0;
  logic [LEN_W-1:0]     len_setting  = LEN_RESET;

  answer_t answers_due[$];
  row_t    plan[$];
  int      mismatches   = 0;
  int      results_seen = 0;
  int      quiet_cycles = 0;
  int      burst_left   = 4;
  int      phase_lengths[10] = '{16, 5, 12, 1, 8, 17, 14, 3, 16, 10};

  barcode_whitelist_corrector i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_barcode         (in_barcode),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_barcode (out_result_barcode),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_bases();
    int n;
    n = int'(len_setting);
    if (n == 0) n = 1;
    if (n > BASES) n = BASES;
    return n;
  endfunction

  function automatic logic [BARCODE_W-1:0] base_mask(input int n);
    logic [BARCODE_W-1:0] m;
    m = '0;
    for (int i = 0; i < n * BASE_W; i++) m[i] = 1'b1;
    return m;
  endfunction

  function automatic logic [BARCODE_W-1:0] put_base(input logic [BARCODE_W-1:0] w,
                                                    input int pos,
                                                    input logic [BASE_W-1:0] code);
    logic [BARCODE_W-1:0] r;
    r = w;
    r[pos*BASE_W +: BASE_W] = code;
    return r;
  endfunction

  function automatic bit in_whitelist(input logic [BARCODE_W-1:0] w,
                                      input logic [BARCODE_W-1:0] m);
    foreach (whitelist[i])
      if ((whitelist[i] & m) == (w & m)) return 1'b1;
    return 1'b0;
  endfunction

  // Works out the answer to one beat and updates the table / freeze flag
  task automatic resolve_beat(input logic func, input logic [BARCODE_W-1:0] word,
                              output status_t st, output logic [BARCODE_W-1:0] res);
    int                   n, n_cnt, n_pos, hits;
    logic [BARCODE_W-1:0] m, q, cand, found;
    logic [BASE_W-1:0]    orig;
    n = eff_bases();
    m = base_mask(n);
    q = word & m;
    res = '0;
    found = '0;
    hits = 0;
    n_cnt = 0;
    n_pos = 0;
    if (func == FUNC_LOAD) begin
      if (loads_frozen || whitelist.size() >= DEPTH) begin
        st = ST_IGNORED;
      end else if (in_whitelist(q, m)) begin
        loads_frozen = 1'b1;
        st = ST_DUPLICATE;
      end else begin
        whitelist.push_back(word & base_mask(BASES));
        st = ST_STORED;
      end
    end else if (in_whitelist(q, m)) begin
      st = ST_EXACT;
      res = q;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (q[i*BASE_W +: BASE_W] == BASE_N) begin
          if (n_cnt == 0) n_pos = i;
          n_cnt++;
        end
      end
      // one N: fill it with each real base; no N: every single substitution
      if (n_cnt == 1) begin
        for (int b = int'(BASE_A); b <= int'(BASE_T); b++) begin
          cand = put_base(q, n_pos, BASE_W'(b));
          if (in_whitelist(cand, m)) begin
            hits++;
            found = cand;
          end
        end
      end else if (n_cnt == 0) begin
        for (int i = 0; i < n; i++) begin
          orig = q[i*BASE_W +: BASE_W];
          for (int b = int'(BASE_A); b <= int'(BASE_T); b++) begin
            if (BASE_W'(b) != orig) begin
              cand = put_base(q, i, BASE_W'(b));
              if (in_whitelist(cand, m)) begin
                hits++;
                found = cand;
              end
            end
          end
        end
      end
      if (hits == 1) begin
        st = ST_CORRECTED;
        res = found & m;
      end else if (hits == 0) begin
        st = ST_NOMATCH;
      end else begin
        st = ST_AMBIGUOUS;
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [BARCODE_W-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[BARCODE_W-1:0];
  endfunction

  // New whitelist entry: a neighbor of a stored one, random bits, or random ACGT
  function automatic logic [BARCODE_W-1:0] fresh_entry(input int n);
    logic [BARCODE_W-1:0] w;
    if (whitelist.size() != 0 && $urandom_range(0, 1) == 0) begin
      w = whitelist[$urandom_range(0, whitelist.size() - 1)];
      w = put_base(w, $urandom_range(0, n - 1), BASE_W'($urandom_range(0, 3)));
    end else if ($urandom_range(0, 1) == 0) begin
      w = rand_word();
    end else begin
      w = '0;
      for (int i = 0; i < BASES; i++) w = put_base(w, i, BASE_W'($urandom_range(0, 3)));
    end
    return w;
  endfunction

  // Query mostly derived from a stored entry, noise above the bases in use
  function automatic logic [BARCODE_W-1:0] fresh_query(input int n,
                                                       input logic [BARCODE_W-1:0] m);
    logic [BARCODE_W-1:0] w;
    int                   p, p2;
    if (whitelist.size() != 0 && $urandom_range(0, 9) < 8)
      w = whitelist[$urandom_range(0, whitelist.size() - 1)];
    else
      w = rand_word();
    w = (w & m) | (rand_word() & ~m);
    p = $urandom_range(0, n - 1);
    p2 = (p + 1) % n;
    case ($urandom_range(0, 9))
      2, 3, 4: w = put_base(w, p, BASE_W'($urandom_range(0, 7)));
      5, 6: w = put_base(w, p, BASE_N);
      7: w = put_base(put_base(w, p, BASE_N), p2, BASE_N);
      8: w = put_base(put_base(w, p, BASE_W'($urandom_range(0, 3))),
                      $urandom_range(0, n - 1), BASE_W'($urandom_range(0, 3)));
      9: w = rand_word();
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_row(input row_kind_t kind, input logic func,
                         input logic [BARCODE_W-1:0] word, input bit typed,
                         input status_t st, input logic [BARCODE_W-1:0] res);
    row_t r;
    r.kind = kind;
    r.func = func;
    r.word = word;
    r.typed = typed;
    r.st = st;
    r.res = res;
    plan.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [BARCODE_W-1:0] got,
                                 input logic [BARCODE_W-1:0] want);
    mismatches++;
    $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Holds one beat on the inputs until taken; start stays high on return
  task automatic issue_beat(input logic func, input logic [BARCODE_W-1:0] word,
                            input bit typed, input status_t want_st,
                            input logic [BARCODE_W-1:0] want_res);
    status_t              st;
    logic [BARCODE_W-1:0] res;
    start <= 1'b1;
    in_func <= func;
    in_barcode <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    resolve_beat(func, word, st, res);
    if (typed) answers_due.push_back('{want_st, want_res});
    else answers_due.push_back('{st, res});
  endtask

  // Bursts of back-to-back beats, random gaps in between
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_setting = value;
  endtask

  // Random load (never a collision before the final phase) or query
  task automatic random_beat();
    int                   n;
    logic [BARCODE_W-1:0] m, word;
    bit                   as_load;
    n = eff_bases();
    m = base_mask(n);
    as_load = 1'b0;
    word = '0;
    if ($urandom_range(0, 99) < ((n >= 8) ? 35 : 10) && whitelist.size() < ENTRY_CAP) begin
      for (int tries = 0; tries < 8 && !as_load; tries++) begin
        word = fresh_entry(n);
        as_load = !in_whitelist(word & m, m);
      end
    end
    if (!as_load) word = fresh_query(n, m);
    issue_beat(as_load ? FUNC_LOAD : FUNC_QUERY, word, 1'b0, ST_EXACT, '0);
    pace_sender();
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_results
    answer_t due;
    if (rst_n && out_valid) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing due", results_seen),
                        out_result_barcode, '0);
      end else begin
        due = answers_due.pop_front();
        if (out_status !== due.st)
          report_mismatch($sformatf("status of result %0d", results_seen),
                          BARCODE_W'(out_status), BARCODE_W'(due.st));
        if (out_result_barcode !== due.res)
          report_mismatch($sformatf("barcode of result %0d", results_seen),
                          out_result_barcode, due.res);
      end
    end
  end

  // Watchdog: cycles with neither a beat taken nor a result shown
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, starting at the reset length of 16 bases
    add_row(ROW_BEAT, FUNC_QUERY, '0, 1'b1, ST_NOMATCH, '0);  // empty table
    add_row(ROW_BEAT, FUNC_LOAD, '0, 1'b1, ST_STORED, '0);
    add_row(ROW_BEAT, FUNC_LOAD, ALL_ONES, 1'b1, ST_STORED, '0);
    add_row(ROW_BEAT, FUNC_QUERY, '0, 1'b1, ST_EXACT, '0);
    add_row(ROW_BEAT, FUNC_QUERY, ALL_ONES, 1'b1, ST_EXACT, ALL_ONES);
    add_row(ROW_BEAT, FUNC_QUERY, put_base('0, 7, BASE_T), 1'b1, ST_CORRECTED, '0);
    add_row(ROW_BEAT, FUNC_QUERY, put_base('0, 15, BASE_N), 1'b1, ST_CORRECTED, '0);
    // two Ns
    add_row(ROW_BEAT, FUNC_QUERY, put_base(put_base('0, 0, BASE_N), 1, BASE_N),
            1'b1, ST_NOMATCH, '0);
    // odd base code gets all four substitutions
    add_row(ROW_BEAT, FUNC_QUERY, put_base('0, 3, BASE_ODD), 1'b1, ST_CORRECTED, '0);
    // N fill never produces an odd code
    add_row(ROW_BEAT, FUNC_QUERY, put_base(ALL_ONES, 0, BASE_N), 1'b1, ST_NOMATCH, '0);
    add_row(ROW_BEAT, FUNC_LOAD, put_base('0, 0, BASE_G), 1'b1, ST_STORED, '0);
    add_row(ROW_BEAT, FUNC_LOAD, put_base('0, 0, BASE_C), 1'b1, ST_STORED, '0);
    add_row(ROW_BEAT, FUNC_QUERY, put_base('0, 0, BASE_T), 1'b1, ST_AMBIGUOUS, '0);
    add_row(ROW_BEAT, FUNC_QUERY, put_base('0, 0, BASE_N), 1'b1, ST_AMBIGUOUS, '0);
    add_row(ROW_BEAT, FUNC_QUERY, put_base('0, 1, BASE_G), 1'b0, ST_EXACT, '0);
    add_row(ROW_BEAT, FUNC_QUERY, put_base(put_base('0, 0, BASE_N), 5, BASE_T),
            1'b0, ST_EXACT, '0);
    add_row(ROW_BEAT, FUNC_LOAD, put_base(put_base('0, 2, BASE_T), 9, BASE_C),
            1'b1, ST_STORED, '0);
    // length 0 acts as one base; upper bits ignored
    add_row(ROW_LEN, FUNC_LOAD, 48'd0, 1'b0, ST_EXACT, '0);
    add_row(ROW_BEAT, FUNC_QUERY, put_base(ALL_ONES, 0, BASE_A), 1'b1, ST_EXACT, '0);
    add_row(ROW_BEAT, FUNC_QUERY, put_base('0, 0, BASE_T), 1'b1, ST_AMBIGUOUS, '0);
    add_row(ROW_BEAT, FUNC_LOAD, put_base(ALL_ONES, 0, BASE_T), 1'b1, ST_STORED, '0);
    // length above the maximum acts as the maximum
    add_row(ROW_LEN, FUNC_LOAD, 48'd31, 1'b0, ST_EXACT, '0);
    add_row(ROW_BEAT, FUNC_QUERY, put_base(ALL_ONES, 0, BASE_T), 1'b1, ST_EXACT,
            put_base(ALL_ONES, 0, BASE_T));
    add_row(ROW_BEAT, FUNC_QUERY, put_base(ALL_ONES, 0, BASE_N), 1'b1, ST_CORRECTED,
            put_base(ALL_ONES, 0, BASE_T));

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_LEN) begin
        set_length(plan[k].word[LEN_W-1:0]);
      end else begin
        issue_beat(plan[k].func, plan[k].word, plan[k].typed, plan[k].st, plan[k].res);
        pace_sender();
      end
    end

    // Random traffic, one length setting per phase
    foreach (phase_lengths[p]) begin
      set_length(LEN_W'(phase_lengths[p]));
      repeat (36) random_beat();
    end

    // Collision freezes loading; later loads are ignored, queries still answer
    set_length(LEN_RESET);
    issue_beat(FUNC_LOAD, ALL_ONES, 1'b1, ST_DUPLICATE, '0);
    pace_sender();
    issue_beat(FUNC_LOAD, '0, 1'b1, ST_IGNORED, '0);
    pace_sender();
    repeat (30) random_beat();

    drain_results();
    repeat (whitelist.size() + BASES + 8) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
